@@ hdl/ple_pkg.sv @@
// Shared definitions for the positional list engine: operation and status codes,
// port widths, default sizes and the command word broadcast to the cell row.
// No dependencies.
package ple_pkg;

    // Fixed widths of the word fields on the ports.
    localparam int OpcodeW = 3;
    localparam int ItemW   = 32;
    localparam int PosW    = 5;
    localparam int LenW    = 5;
    localparam int StatusW = 2;

    // Default sizes of the list.
    localparam int DepthDefault = 16;
    localparam int WidthDefault = 32;

    // Operation codes.
    localparam logic [OpcodeW-1:0] OpInsFront = 3'd0;
    localparam logic [OpcodeW-1:0] OpInsBack  = 3'd1;
    localparam logic [OpcodeW-1:0] OpInsAt    = 3'd2;
    localparam logic [OpcodeW-1:0] OpRemFront = 3'd3;
    localparam logic [OpcodeW-1:0] OpRemBack  = 3'd4;
    localparam logic [OpcodeW-1:0] OpRemAt    = 3'd5;
    localparam logic [OpcodeW-1:0] OpReadAt   = 3'd6;
    localparam logic [OpcodeW-1:0] OpClear    = 3'd7;

    // Status codes.
    localparam logic [StatusW-1:0] StOk     = 2'd0;
    localparam logic [StatusW-1:0] StEmpty  = 2'd1;
    localparam logic [StatusW-1:0] StBadPos = 2'd2;
    localparam logic [StatusW-1:0] StFull   = 2'd3;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic ins;   // open a gap at the position and store the new word there
        logic rem;   // close the gap at the position by pulling from the right
    } t_cell_cmd;

endpackage

@@ hdl/ple_cell.sv @@
// One storage cell of the positional list row. It holds one entry and decides
// on its own whether to hold, take its left or right neighbor, or take a new word.
// Depends on ple_pkg.
module ple_cell #(
    parameter int WIDTH = ple_pkg::WidthDefault,
    parameter int PW    = ple_pkg::PosW,
    parameter int INDEX = 0
) (
    input  logic                 i_clk,
    input  ple_pkg::t_cell_cmd   i_cmd,
    input  logic [PW-1:0]        i_pos,
    input  logic [WIDTH-1:0]     i_new_data,
    input  logic [WIDTH-1:0]     i_left_data,
    input  logic [WIDTH-1:0]     i_right_data,
    output logic [WIDTH-1:0]     o_data,
    output logic [WIDTH-1:0]     o_tap
);

    localparam logic [PW-1:0] MyIndex = PW'(INDEX);

    logic [WIDTH-1:0] r_data;
    logic [WIDTH-1:0] n_data;
    logic             hit;
    logic             above;

    assign hit   = (i_pos == MyIndex);
    assign above = (MyIndex > i_pos);

    // Local shift decision from the broadcast position.
    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (hit) begin
                n_data = i_new_data;
            end else if (above) begin
                n_data = i_left_data;
            end
        end else if (i_cmd.rem) begin
            if (hit || above) begin
                n_data = i_right_data;
            end
        end
    end

    // Entry storage; never-written entries are never read out.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // Only the addressed cell drives its tap; the top ORs all taps together.
    assign o_tap  = hit ? r_data : '0;

endmodule

@@ hdl/positional_list_engine_unit.sv @@
// Top level of the positional list engine: command decode, length counter,
// result register and the row of ple_cell storage cells.
// Depends on ple_pkg and ple_cell.

// The block keeps an ordered list of up to DEPTH words in a row of cells and
// takes one operation per clock cycle; each result word is registered as its
// operation is accepted and is held in the output register while stalled,
// during which no new operation is accepted. Every cell compares its own index
// with the broadcast position and shifts or holds locally, so the cycle is set
// by that compare plus the one-hot read-out of the addressed cell. Errors (empty
// list, bad position, full list) are reported in the status and leave the list
// unchanged. Entries are not reset; only the length and the output valid are.
module positional_list_engine_unit #(
    parameter int DEPTH = ple_pkg::DepthDefault,
    parameter int WIDTH = ple_pkg::WidthDefault
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ple_pkg::OpcodeW-1:0]       i_opcode,
    input  logic signed [ple_pkg::ItemW-1:0]  i_item_value,
    input  logic [ple_pkg::PosW-1:0]          i_position,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [ple_pkg::ItemW-1:0]  o_result_value,
    output logic [ple_pkg::LenW-1:0]          o_length,
    output logic [ple_pkg::StatusW-1:0]       o_status
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (ple_pkg::PosW > CW) ? ple_pkg::PosW : CW;
    localparam logic [CW-1:0] CountMax = CW'(DEPTH);

    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  n_count;
    logic                           r_out_valid;
    logic [ple_pkg::ItemW-1:0]      r_result;
    logic [ple_pkg::ItemW-1:0]      n_result;
    logic [ple_pkg::LenW-1:0]       r_length;
    logic [ple_pkg::StatusW-1:0]    r_status;
    logic [ple_pkg::StatusW-1:0]    n_status;

    logic                           accept;
    logic                           ok_ins;
    logic                           ok_rem;
    logic [PW-1:0]                  pos_in;
    logic [PW-1:0]                  cnt_w;
    logic [PW-1:0]                  sel_pos;
    logic                           full;
    logic [WIDTH-1:0]               new_word;
    logic [WIDTH-1:0]               tap_or;
    logic [ple_pkg::ItemW-1:0]      tap_ext;
    ple_pkg::t_cell_cmd             cmd;

    logic [WIDTH-1:0]               w_data [DEPTH];
    logic [WIDTH-1:0]               w_tap  [DEPTH];

    // Handshake: a held result blocks the input only while the output stalls.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign pos_in = PW'(i_position);
    assign cnt_w  = PW'(r_count);
    assign full   = (r_count == CountMax);

    // Position the operation works on.
    always_comb begin
        case (i_opcode)
            ple_pkg::OpInsFront, ple_pkg::OpRemFront: sel_pos = '0;
            ple_pkg::OpInsBack:                       sel_pos = cnt_w;
            ple_pkg::OpRemBack:                       sel_pos = cnt_w - PW'(1);
            default:                                  sel_pos = pos_in;
        endcase
    end

    // Low WIDTH bits of the input word, zero above bit 31.
    always_comb begin
        for (int k = 0; k < WIDTH; k++) begin
            new_word[k] = (k < ple_pkg::ItemW) ? i_item_value[k] : 1'b0;
        end
    end

    // Read-out: OR of the taps, where only the addressed cell is nonzero.
    always_comb begin
        tap_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            tap_or = tap_or | w_tap[k];
        end
    end

    // Sign extension of the read word from WIDTH bits to the port width.
    always_comb begin
        for (int k = 0; k < ple_pkg::ItemW; k++) begin
            tap_ext[k] = (k < WIDTH) ? tap_or[k] : tap_or[WIDTH-1];
        end
    end

    // Operation decode: status, new length and value touched.
    always_comb begin
        ok_ins   = 1'b0;
        ok_rem   = 1'b0;
        n_status = ple_pkg::StOk;
        n_result = '0;
        n_count  = r_count;
        case (i_opcode)
            ple_pkg::OpInsFront, ple_pkg::OpInsBack, ple_pkg::OpInsAt: begin
                if (sel_pos > cnt_w) begin
                    n_status = ple_pkg::StBadPos;
                end else if (full) begin
                    n_status = ple_pkg::StFull;
                end else begin
                    ok_ins  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            ple_pkg::OpRemFront, ple_pkg::OpRemBack, ple_pkg::OpRemAt: begin
                if (r_count == '0) begin
                    n_status = ple_pkg::StEmpty;
                end else if (sel_pos >= cnt_w) begin
                    n_status = ple_pkg::StBadPos;
                end else begin
                    ok_rem   = 1'b1;
                    n_result = tap_ext;
                    n_count  = r_count - CW'(1);
                end
            end
            ple_pkg::OpReadAt: begin
                if (sel_pos >= cnt_w) begin
                    n_status = ple_pkg::StBadPos;
                end else begin
                    n_result = tap_ext;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    assign cmd = '{ins: accept && ok_ins, rem: accept && ok_rem};

    // Row of cells; each one sees its two neighbors.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WIDTH-1:0] left_data;
        logic [WIDTH-1:0] right_data;

        if (g == 0) begin : g_first
            assign left_data = '0;
        end else begin : g_mid
            assign left_data = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_data = '0;
        end else begin : g_inner
            assign right_data = w_data[g+1];
        end

        ple_cell #(
            .WIDTH (WIDTH),
            .PW    (PW),
            .INDEX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cmd),
            .i_pos        (sel_pos),
            .i_new_data   (new_word),
            .i_left_data  (left_data),
            .i_right_data (right_data),
            .o_data       (w_data[g]),
            .o_tap        (w_tap[g])
        );
    end

    // Length counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
            r_length <= ple_pkg::LenW'(n_count);
            r_status <= n_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_result;
    assign o_length       = r_length;
    assign o_status       = r_status;

    // The length never exceeds the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountMax)
        else $error("list length exceeds depth");

    // A clear always yields an empty list in the next result.
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == ple_pkg::OpClear) |=> (o_out_valid && o_length == '0))
        else $error("clear did not empty the list");

    // A full report only comes from a full list, which it leaves unchanged.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ple_pkg::StFull) |-> (r_count == CountMax))
        else $error("full status with a list that is not full");

    // A successful insert grows the list by exactly one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list by one");

endmodule

@@ tb/sv/positional_list_engine_unit_test.sv @@
// Self-checking testbench for positional_list_engine_unit: a queue-fed driver, a
// stalling monitor and an in-bench model of the bounded list that predicts every word.
// Depends on ple_pkg and the positional_list_engine_unit RTL.
module positional_list_engine_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ListDepth   = ple_pkg::DepthDefault;
    localparam int RandomCount = 1950;

    typedef struct {
        logic [ple_pkg::OpcodeW-1:0]      opcode;
        logic signed [ple_pkg::ItemW-1:0] value;
        logic [ple_pkg::PosW-1:0]         position;
        bit                               drain_first;
    } t_op_word;

    typedef struct {
        logic signed [ple_pkg::ItemW-1:0] value;
        logic [ple_pkg::LenW-1:0]         length;
        logic [ple_pkg::StatusW-1:0]      status;
    } t_result_word;

    logic                               i_clk          = 1'b0;
    logic                               i_rst_n        = 1'b0;
    logic                               i_in_valid     = 1'b0;
    logic                               o_in_stall;
    logic [ple_pkg::OpcodeW-1:0]        i_opcode       = '0;
    logic signed [ple_pkg::ItemW-1:0]   i_item_value   = '0;
    logic [ple_pkg::PosW-1:0]           i_position     = '0;
    logic                               o_out_valid;
    logic                               i_out_stall    = 1'b0;
    logic signed [ple_pkg::ItemW-1:0]   o_result_value;
    logic [ple_pkg::LenW-1:0]           o_length;
    logic [ple_pkg::StatusW-1:0]        o_status;

    t_op_word     pending_ops[$];
    t_result_word expected_results[$];
    int unsigned  mismatch_count = 0;

    // Model copy of the list contents and its length.
    logic signed [ple_pkg::ItemW-1:0] list_words [ListDepth];
    int unsigned                      list_len = 0;

    // Stimulus-side length tracker used to aim positions.
    int unsigned gen_len = 0;

    int unsigned  send_gap   = 0;
    int unsigned  stall_left = 0;
    bit           took_word;
    t_op_word     next_word;
    t_result_word got_word;
    t_result_word want_word;

    positional_list_engine_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_item_value   (i_item_value),
        .i_position     (i_position),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_length       (o_length),
        .o_status       (o_status)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Reset is held low at the start of the run and then released.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Gap lengths: mostly none, some short, a few long; calm stretches have none at all.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if ((($time / 5120) % 4) == 0) return 0;
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Apply one operation to the model list and return the word the block should answer.
    function automatic t_result_word apply_list_op(logic [ple_pkg::OpcodeW-1:0] op,
                                                   logic signed [ple_pkg::ItemW-1:0] val,
                                                   logic [ple_pkg::PosW-1:0] pos);
        t_result_word res;
        int unsigned  idx;
        res.value  = '0;
        res.status = ple_pkg::StOk;
        case (op)
            ple_pkg::OpInsFront, ple_pkg::OpInsBack, ple_pkg::OpInsAt: begin
                idx = (op == ple_pkg::OpInsFront) ? 0 :
                      (op == ple_pkg::OpInsBack) ? list_len : pos;
                if (idx > list_len) begin
                    res.status = ple_pkg::StBadPos;
                end else if (list_len >= ListDepth) begin
                    res.status = ple_pkg::StFull;
                end else begin
                    for (int i = list_len; i > idx; i--) list_words[i] = list_words[i-1];
                    list_words[idx] = val;
                    list_len++;
                end
            end
            ple_pkg::OpRemFront, ple_pkg::OpRemBack, ple_pkg::OpRemAt: begin
                if (list_len == 0) begin
                    res.status = ple_pkg::StEmpty;
                end else begin
                    idx = (op == ple_pkg::OpRemFront) ? 0 :
                          (op == ple_pkg::OpRemBack) ? list_len - 1 : pos;
                    if (idx >= list_len) begin
                        res.status = ple_pkg::StBadPos;
                    end else begin
                        res.value = list_words[idx];
                        for (int i = idx; i + 1 < list_len; i++)
                            list_words[i] = list_words[i+1];
                        list_len--;
                    end
                end
            end
            ple_pkg::OpReadAt: begin
                if (pos >= list_len) res.status = ple_pkg::StBadPos;
                else res.value = list_words[pos];
            end
            default: begin
                list_len = 0;
            end
        endcase
        res.length = list_len[ple_pkg::LenW-1:0];
        return res;
    endfunction

    // Length after an operation, so the generator can aim positions at live entries.
    function automatic int unsigned track_len(logic [ple_pkg::OpcodeW-1:0] op,
                                              logic [ple_pkg::PosW-1:0] pos,
                                              int unsigned len);
        int unsigned idx;
        case (op)
            ple_pkg::OpInsFront, ple_pkg::OpInsBack, ple_pkg::OpInsAt: begin
                idx = (op == ple_pkg::OpInsFront) ? 0 :
                      (op == ple_pkg::OpInsBack) ? len : pos;
                return (idx > len || len >= ListDepth) ? len : len + 1;
            end
            ple_pkg::OpRemFront, ple_pkg::OpRemBack, ple_pkg::OpRemAt: begin
                if (len == 0) return 0;
                idx = (op == ple_pkg::OpRemFront) ? 0 :
                      (op == ple_pkg::OpRemBack) ? len - 1 : pos;
                return (idx >= len) ? len : len - 1;
            end
            ple_pkg::OpReadAt: return len;
            default:  return 0;
        endcase
    endfunction

    task automatic queue_op(logic [ple_pkg::OpcodeW-1:0] op,
                            logic signed [ple_pkg::ItemW-1:0] val,
                            logic [ple_pkg::PosW-1:0] pos, bit drain);
        t_op_word w;
        w.opcode      = op;
        w.value       = val;
        w.position    = pos;
        w.drain_first = drain;
        pending_ops.push_back(w);
        gen_len = track_len(op, pos, gen_len);
    endtask

    function automatic logic signed [ple_pkg::ItemW-1:0] random_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3) return 32'sh8000_0000;
        if (r < 6) return 32'sh7FFF_FFFF;
        if (r < 8) return '0;
        if (r < 10) return -32'sd1;
        return $urandom;
    endfunction

    // Driver: record each accepted word in the model, then present the next one or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            took_word = i_in_valid;
            if (took_word) begin
                expected_results.push_back(apply_list_op(i_opcode, i_item_value, i_position));
            end
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_ops.size() != 0 &&
                         (!pending_ops[0].drain_first ||
                          (!took_word && expected_results.size() == 0))) begin
                next_word = pending_ops.pop_front();
                i_opcode     <= next_word.opcode;
                i_item_value <= next_word.value;
                i_position   <= next_word.position;
                i_in_valid   <= 1'b1;
                send_gap = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random output stalls, and every accepted result word is checked in order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got_word.value  = o_result_value;
                got_word.length = o_length;
                got_word.status = o_status;
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result word: value %0d length %0d status %0d",
                                 got_word.value, got_word.length, got_word.status);
                    mismatch_count++;
                end else begin
                    want_word = expected_results.pop_front();
                    if (got_word.value !== want_word.value ||
                        got_word.length !== want_word.length ||
                        got_word.status !== want_word.status) begin
                        if (mismatch_count < 10)
                            $display({"mismatch: expected value %0d length %0d status %0d,",
                                      " got value %0d length %0d status %0d"},
                                     want_word.value, want_word.length, want_word.status,
                                     got_word.value, got_word.length, got_word.status);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    // Stimulus, then wait for the last result word and report.
    initial begin
        int unsigned target;
        int unsigned r;
        logic [ple_pkg::OpcodeW-1:0] op;
        logic [ple_pkg::PosW-1:0]    pos;
        bit                          grow;

        // Removing or reading from an empty list, and inserting past its end.
        queue_op(ple_pkg::OpRemFront, '0, '0, 1'b0);
        queue_op(ple_pkg::OpRemBack, '0, '0, 1'b0);
        queue_op(ple_pkg::OpRemAt, '0, 5'd0, 1'b0);
        queue_op(ple_pkg::OpReadAt, '0, 5'd0, 1'b0);
        queue_op(ple_pkg::OpInsAt, 32'sd5, 5'd1, 1'b0);
        // Fill to capacity with every insert flavor and the extreme words.
        queue_op(ple_pkg::OpInsFront, 32'sh8000_0000, '0, 1'b0);
        queue_op(ple_pkg::OpInsBack, 32'sh7FFF_FFFF, '0, 1'b0);
        queue_op(ple_pkg::OpInsAt, -32'sd1, 5'd1, 1'b0);
        queue_op(ple_pkg::OpInsAt, 32'sd0, 5'd3, 1'b0);
        for (int i = 0; i < 12; i++)
            queue_op(ple_pkg::OpInsAt, $urandom, 5'($urandom_range(0, gen_len)), 1'b0);
        // Full list: plain insert is refused, an out-of-range position reports first.
        queue_op(ple_pkg::OpInsBack, 32'sd9, '0, 1'b0);
        queue_op(ple_pkg::OpInsAt, 32'sd9, 5'd31, 1'b0);
        queue_op(ple_pkg::OpReadAt, '0, 5'd15, 1'b0);
        queue_op(ple_pkg::OpReadAt, '0, 5'd16, 1'b0);
        queue_op(ple_pkg::OpRemAt, '0, 5'd16, 1'b0);
        queue_op(ple_pkg::OpRemAt, '0, 5'd7, 1'b0);
        queue_op(ple_pkg::OpClear, '0, '0, 1'b0);

        // Random part: mostly operations aimed at live positions, swept between empty and full.
        target = ListDepth;
        for (int n = 0; n < RandomCount; n++) begin
            if (gen_len == target) begin
                r = $urandom_range(0, 99);
                target = (r < 25) ? 0 : (r < 50) ? ListDepth : $urandom_range(0, ListDepth);
            end
            r = $urandom_range(0, 99);
            if (r < 3) begin
                op  = ple_pkg::OpClear;
                pos = 5'($urandom);
            end else if (r < 18) begin
                op  = ple_pkg::OpReadAt;
                pos = (gen_len > 0) ? 5'($urandom_range(0, gen_len - 1)) : 5'd0;
            end else if (r < 24) begin
                op  = 3'($urandom);
                pos = 5'($urandom);
            end else begin
                grow = (gen_len < target) ? ($urandom_range(0, 99) < 80)
                                          : ($urandom_range(0, 99) < 20);
                case ($urandom_range(0, 2))
                    0:       op = grow ? ple_pkg::OpInsFront : ple_pkg::OpRemFront;
                    1:       op = grow ? ple_pkg::OpInsBack : ple_pkg::OpRemBack;
                    default: op = grow ? ple_pkg::OpInsAt : ple_pkg::OpRemAt;
                endcase
                if (grow) pos = 5'($urandom_range(0, gen_len));
                else pos = (gen_len > 0) ? 5'($urandom_range(0, gen_len - 1)) : 5'd0;
            end
            queue_op(op, random_value(), pos, (n == 700) || (n == 1400));
        end

        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (pending_ops.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog in case the block stops answering.
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/positional_list_engine_unit.sv
tb/sv/positional_list_engine_unit_test.sv
